// ===== rtl/core/hslc_pkg.sv =====
// ----------------------------------------------------------------------------
// hslc_pkg
// Shared constants and stage payload types for the HSL/RGB converter.
// ----------------------------------------------------------------------------
package hslc_pkg;

  localparam int unsigned HueSector = 3840;
  localparam int unsigned HueFull   = 23040;
  localparam int unsigned CompMax   = 255;

  // Pipeline depth of the divider (one quotient bit per stage).
  localparam int unsigned DivBits   = 15;

  // Setup stage, divider stages, final stage.
  localparam int unsigned PipeDepth = DivBits + 2;

  typedef enum logic {
    OP_HSL2RGB = 1'b0,
    OP_RGB2HSL = 1'b1
  } op_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  light;
  } hsl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

// ===== rtl/core/hslc_pipe_ctl.sv =====
// ----------------------------------------------------------------------------
// hslc_pipe_ctl
// Valid chain and stall control for an N-stage elastic pipeline.
// ----------------------------------------------------------------------------
module hslc_pipe_ctl #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Depth-1:0] stage_en,
  output logic [Depth-1:0] stage_valid
);

  logic [Depth-1:0] vld;
  logic [Depth:0]   adv;

  // A stage may load when its slot frees up downstream.
  always_comb begin
    adv[Depth] = out_ready || !vld[Depth-1];
    for (int i = Depth - 1; i >= 1; i--) begin
      adv[i] = adv[i+1] || !vld[i-1];
    end
    adv[0] = adv[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < Depth; i++) begin
        if (adv[i+1]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      stage_en[i] = adv[i+1];
    end
  end

  assign in_ready    = adv[1];
  assign out_valid   = vld[Depth-1];
  assign stage_valid = vld;

endmodule

// ===== rtl/core/hslc_h2r.sv =====
// ----------------------------------------------------------------------------
// hslc_h2r
// HSL to RGB datapath: chroma, sector pick, offset, truncate and clamp.
// Four stages, advanced by en[3:0].
// ----------------------------------------------------------------------------
module hslc_h2r
  import hslc_pkg::*;
(
  input  logic       clk,
  input  logic [3:0] en,
  input  hsl_t       hsl,
  output rgb_t       rgb
);

  // 255*7680 = 512*3825: shift out 512, then multiply by ceil(2^32/3825).
  localparam int unsigned        RecipK     = 1122868;
  localparam logic signed [31:0] ClampLimit = 32'sd501350400;

  // Stage 1: chroma numerator, hue sector and triangle weight.
  logic [15:0] cn1;
  logic [2:0]  sec1;
  logic [12:0] w1;
  logic [7:0]  l1;
  logic [8:0]  d_abs;
  logic [12:0] t_mod;
  logic [12:0] t_abs;
  logic [2:0]  sec_raw;

  always_comb begin
    d_abs = ({1'b0, hsl.light} << 1) >= 9'(CompMax) ?
            ({1'b0, hsl.light} << 1) - 9'(CompMax) :
            9'(CompMax) - ({1'b0, hsl.light} << 1);
    // hue mod 7680 by compare and subtract
    if (hsl.hue >= 15'(8 * HueSector))      t_mod = 13'(hsl.hue - 15'(8 * HueSector));
    else if (hsl.hue >= 15'(6 * HueSector)) t_mod = 13'(hsl.hue - 15'(6 * HueSector));
    else if (hsl.hue >= 15'(4 * HueSector)) t_mod = 13'(hsl.hue - 15'(4 * HueSector));
    else if (hsl.hue >= 15'(2 * HueSector)) t_mod = 13'(hsl.hue - 15'(2 * HueSector));
    else                                    t_mod = 13'(hsl.hue);
    t_abs = t_mod >= 13'(HueSector) ? t_mod - 13'(HueSector) : 13'(HueSector) - t_mod;
    if (hsl.hue >= 15'(5 * HueSector))      sec_raw = 3'd5;
    else if (hsl.hue >= 15'(4 * HueSector)) sec_raw = 3'd4;
    else if (hsl.hue >= 15'(3 * HueSector)) sec_raw = 3'd3;
    else if (hsl.hue >= 15'(2 * HueSector)) sec_raw = 3'd2;
    else if (hsl.hue >= 15'(HueSector))     sec_raw = 3'd1;
    else                                    sec_raw = 3'd0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cn1  <= 16'(16'(9'(CompMax) - d_abs) * 16'(hsl.sat));
      sec1 <= sec_raw;
      w1   <= 13'(HueSector) - t_abs;
      l1   <= hsl.light;
    end
  end

  // Stage 2: scaled C, X and offset m (units 1/(255*255*7680)).
  logic [29:0] cv2;
  logic [29:0] xv2;
  logic [30:0] mv2;
  logic [2:0]  sec2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cv2  <= 30'(30'(cn1) * 30'(2 * HueSector));
      xv2  <= 30'(30'(cn1) * 30'(w1)) << 1;
      mv2  <= 31'($signed(31'(31'(l1) * 31'(CompMax * 2 * HueSector)))
                 - $signed(31'(31'(cn1) * 31'(HueSector))));
      sec2 <= sec1;
    end
  end

  // Stage 3: sector permutation plus offset.
  logic signed [31:0] r3, g3, b3;
  logic signed [31:0] cs, xs, ms;

  always_comb begin
    cs = $signed({2'b0, cv2});
    xs = $signed({2'b0, xv2});
    ms = $signed({mv2[30], mv2});
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      case (sec2)
        3'd0:    begin r3 <= cs + ms; g3 <= xs + ms; b3 <= ms;      end
        3'd1:    begin r3 <= xs + ms; g3 <= cs + ms; b3 <= ms;      end
        3'd2:    begin r3 <= ms;      g3 <= cs + ms; b3 <= xs + ms; end
        3'd3:    begin r3 <= ms;      g3 <= xs + ms; b3 <= cs + ms; end
        3'd4:    begin r3 <= xs + ms; g3 <= ms;      b3 <= cs + ms; end
        default: begin r3 <= cs + ms; g3 <= ms;      b3 <= xs + ms; end
      endcase
    end
  end

  // Stage 4: divide by 255*7680 and clamp.
  function automatic logic [7:0] clamp_div(input logic signed [31:0] v);
    logic [19:0] u;
    logic [40:0] p;
    begin
      u = v[28:9];
      p = 41'(u) * 41'(RecipK);
      if (v < 0) clamp_div = 8'd0;
      else if (v >= ClampLimit) clamp_div = 8'(CompMax);
      else clamp_div = p[39:32];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rgb.red   <= clamp_div(r3);
      rgb.green <= clamp_div(g3);
      rgb.blue  <= clamp_div(b3);
    end
  end

endmodule

// ===== rtl/core/hslc_r2h.sv =====
// ----------------------------------------------------------------------------
// hslc_r2h
// RGB to HSL datapath: max/min, then a pipelined restoring divider for hue
// and saturation, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hslc_r2h
  import hslc_pkg::*;
(
  input  logic                 clk,
  input  logic [PipeDepth-1:0] en,
  input  rgb_t                 rgb,
  output hsl_t                 hsl
);

  localparam int unsigned NumW = 2 * DivBits + 1;

  // Stage 0: max, min, and the hue and saturation fractions.
  logic [7:0]  mx, mn, c;
  logic [8:0]  den_abs, sden;
  logic [NumW-1:0] hnum, snum;
  logic        c_zero;

  always_comb begin
    mx = rgb.red;
    if (rgb.green > mx) mx = rgb.green;
    if (rgb.blue > mx)  mx = rgb.blue;
    mn = rgb.red;
    if (rgb.green < mn) mn = rgb.green;
    if (rgb.blue < mn)  mn = rgb.blue;
    c = mx - mn;
    c_zero = (c == 8'd0);
    if (rgb.red >= rgb.green && rgb.red >= rgb.blue) begin
      if (rgb.green >= rgb.blue)
        hnum = NumW'((rgb.green - rgb.blue) * 32'(HueSector));
      else
        hnum = NumW'(32'(HueFull) * c - 32'(rgb.blue - rgb.green) * 32'(HueSector));
    end else if (rgb.green >= rgb.blue) begin
      hnum = NumW'(32'(rgb.blue) * 32'(HueSector) + 32'(2 * HueSector) * c
                   - 32'(rgb.red) * 32'(HueSector));
    end else begin
      hnum = NumW'(32'(rgb.red) * 32'(HueSector) + 32'(4 * HueSector) * c
                   - 32'(rgb.green) * 32'(HueSector));
    end
    den_abs = ({1'b0, mx} + {1'b0, mn}) >= 9'(CompMax) ?
              {1'b0, mx} + {1'b0, mn} - 9'(CompMax) :
              9'(CompMax) - {1'b0, mx} - {1'b0, mn};
    sden = 9'(CompMax) - den_abs;
    snum = NumW'(32'(CompMax) * c);
  end

  // Divider pipeline: stage i settles quotient bit DivBits-1-i.
  logic [NumW-1:0] hrem [DivBits+1];
  logic [NumW-1:0] srem [DivBits+1];
  logic [7:0]      hden [DivBits+1];
  logic [8:0]      sd   [DivBits+1];
  logic [DivBits-1:0] hq [DivBits+1];
  logic [DivBits-1:0] sq [DivBits+1];
  logic            cz   [DivBits+1];
  logic [7:0]      lt   [DivBits+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hrem[0] <= hnum;
      srem[0] <= snum;
      hden[0] <= c;
      sd[0]   <= sden;
      hq[0]   <= '0;
      sq[0]   <= '0;
      cz[0]   <= c_zero;
      lt[0]   <= 8'((9'(mx) + 9'(mn)) >> 1);
    end
  end

  for (genvar i = 0; i < DivBits; i++) begin : g_div
    localparam int unsigned B = DivBits - 1 - i;
    logic [NumW-1:0] hsh, ssh;
    always_comb begin
      hsh = NumW'(hden[i]) << B;
      ssh = NumW'(sd[i]) << B;
    end
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        if (hrem[i] >= hsh) begin
          hrem[i+1] <= hrem[i] - hsh;
          hq[i+1]   <= hq[i] | (DivBits'(1) << B);
        end else begin
          hrem[i+1] <= hrem[i];
          hq[i+1]   <= hq[i];
        end
        if (srem[i] >= ssh) begin
          srem[i+1] <= srem[i] - ssh;
          sq[i+1]   <= sq[i] | (DivBits'(1) << B);
        end else begin
          srem[i+1] <= srem[i];
          sq[i+1]   <= sq[i];
        end
        hden[i+1] <= hden[i];
        sd[i+1]   <= sd[i];
        cz[i+1]   <= cz[i];
        lt[i+1]   <= lt[i];
      end
    end
  end

  // Final stage: zero-chroma override, hue clip and saturation clip.
  always_ff @(posedge clk) begin
    if (en[PipeDepth-1]) begin
      hsl.light <= lt[DivBits];
      if (cz[DivBits]) begin
        hsl.hue <= '0;
        hsl.sat <= '0;
      end else begin
        hsl.hue <= (hq[DivBits] >= 15'(HueFull)) ? 15'(HueFull - 1) : hq[DivBits];
        hsl.sat <= (sd[DivBits] == 9'd0 || sq[DivBits] > 15'(CompMax)) ?
                   8'(CompMax) : sq[DivBits][7:0];
      end
    end
  end

endmodule

// ===== rtl/core/hsl_rgb_converter_unit.sv =====
// ----------------------------------------------------------------------------
// hsl_rgb_converter_unit
// Per-pixel converter between 8-bit RGB and HSL, selected by operation.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  input    valid / ready      operation, red_in..blue_in, hue_in, saturation_in,
//                              lightness_in
//  output   out_valid / out_ready  red_out..blue_out, hue_out, saturation_out,
//                              lightness_out
//
// One pixel per clock unless out_ready stalls. Stages: one setup stage,
// the 15-stage hue and saturation divider and one final stage. The HSL
// to RGB path is shorter and is delay matched. Reset clears only the valid
// chain. A stall holds valid stages with no bubble ahead; bubbles collapse.
// ----------------------------------------------------------------------------
module hsl_rgb_converter_unit
  import hslc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic        operation,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [14:0] hue_in,
  input  logic [7:0]  saturation_in,
  input  logic [7:0]  lightness_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [14:0] hue_out,
  output logic [7:0]  saturation_out,
  output logic [7:0]  lightness_out
);

  localparam int unsigned Depth = PipeDepth;

  logic [Depth-1:0] en;
  logic [Depth-1:0] svld;
  rgb_t             rgb_res, rgb_d;
  hsl_t             hsl_res;
  hsl_t             hsl_src;
  rgb_t             rgb_src;
  op_t              op_q [Depth];
  rgb_t             rgb_q [Depth-4];

  hslc_pipe_ctl #(.Depth(Depth)) u_ctl (
    .clk, .rst, .in_valid(valid), .in_ready(ready),
    .out_valid, .out_ready, .stage_en(en), .stage_valid(svld)
  );

  assign hsl_src = '{hue: hue_in, sat: saturation_in, light: lightness_in};
  assign rgb_src = '{red: red_in, green: green_in, blue: blue_in};

  hslc_h2r u_h2r (.clk, .en(en[3:0]), .hsl(hsl_src), .rgb(rgb_res));
  hslc_r2h u_r2h (.clk, .en, .rgb(rgb_src), .hsl(hsl_res));

  // Carry the operation along, and delay-match the RGB result.
  always_ff @(posedge clk) begin
    if (en[0]) op_q[0] <= op_t'(operation);
    for (int i = 1; i < Depth; i++) begin
      if (en[i]) op_q[i] <= op_q[i-1];
    end
    if (en[4]) rgb_q[0] <= rgb_res;
    for (int i = 1; i < Depth - 4; i++) begin
      if (en[i+4]) rgb_q[i] <= rgb_q[i-1];
    end
  end

  assign rgb_d = rgb_q[Depth-5];

  always_comb begin
    if (op_q[Depth-1] == OP_RGB2HSL) begin
      red_out = '0; green_out = '0; blue_out = '0;
      hue_out = hsl_res.hue; saturation_out = hsl_res.sat;
      lightness_out = hsl_res.light;
    end else begin
      red_out = rgb_d.red; green_out = rgb_d.green; blue_out = rgb_d.blue;
      hue_out = '0; saturation_out = '0; lightness_out = '0;
    end
  end

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hue_out < 15'(HueFull)) else $error("hue out of range");
  a_out_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid == svld[Depth-1]) else $error("valid chain mismatch");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

// ===== verif/tb_hsl_rgb_converter_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsl_rgb_converter_unit
// Drives HSL and RGB pixels through the converter with random gaps on both
// sides and compares every result against an integer color-space predictor.
// ----------------------------------------------------------------------------
module tb_hsl_rgb_converter_unit;
  import hslc_pkg::*;

  localparam int unsigned Latency = PipeDepth;
  localparam int unsigned WatchLimit = 20000;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  light;
  } color_t;

  logic        clk;
  logic        rst;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  red_in, green_in, blue_in;
  logic [14:0] hue_in;
  logic [7:0]  saturation_in, lightness_in;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  red_out, green_out, blue_out;
  logic [14:0] hue_out;
  logic [7:0]  saturation_out, lightness_out;

  color_t      expected_colors[$];
  int          error_count;
  int          idle_cycles;
  bit          source_throttle;
  bit          sink_throttle;

  hsl_rgb_converter_unit dut (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .operation(operation),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .hue_in(hue_in),
    .saturation_in(saturation_in), .lightness_in(lightness_in),
    .out_valid(out_valid), .out_ready(out_ready), .red_out(red_out),
    .green_out(green_out), .blue_out(blue_out), .hue_out(hue_out),
    .saturation_out(saturation_out), .lightness_out(lightness_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] clamp_channel(longint num);
    longint v;
    if (num < 0) return 8'd0;
    v = num / (longint'(CompMax) * 2 * HueSector);
    if (v > CompMax) v = CompMax;
    return v[7:0];
  endfunction

  function automatic color_t predict_color(op_t op, rgb_t rgb, hsl_t hsl);
    color_t res;
    longint h, s, l, d, cn, t, w, cv, xv, mv, r1, g1, b1, sector;
    longint r, g, b, mx, mn, c, hv, sv, den;
    res = '{default: '0};
    if (op == OP_HSL2RGB) begin
      h = hsl.hue; s = hsl.sat; l = hsl.light;
      d = 2 * l - CompMax;
      if (d < 0) d = -d;
      cn = (CompMax - d) * s;
      t = h % (2 * HueSector);
      w = t - HueSector;
      if (w < 0) w = -w;
      w = HueSector - w;
      cv = cn * 2 * HueSector;
      xv = cn * w * 2;
      mv = l * CompMax * 2 * HueSector - cn * HueSector;
      sector = h / HueSector;
      if (sector > 5) sector = 5;
      case (sector)
        0: begin r1 = cv; g1 = xv; b1 = 0; end
        1: begin r1 = xv; g1 = cv; b1 = 0; end
        2: begin r1 = 0; g1 = cv; b1 = xv; end
        3: begin r1 = 0; g1 = xv; b1 = cv; end
        4: begin r1 = xv; g1 = 0; b1 = cv; end
        default: begin r1 = cv; g1 = 0; b1 = xv; end
      endcase
      res.red = clamp_channel(r1 + mv);
      res.green = clamp_channel(g1 + mv);
      res.blue = clamp_channel(b1 + mv);
    end else begin
      r = rgb.red; g = rgb.green; b = rgb.blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      c = mx - mn;
      hv = 0; sv = 0;
      if (c > 0) begin
        // ties resolve red, then green, then blue
        if (r >= g && r >= b) begin
          if (g >= b) hv = (g - b) * HueSector / c;
          else hv = (longint'(HueFull) * c - (b - g) * HueSector) / c;
        end else if (g >= b) begin
          hv = ((b - r) * HueSector + 2 * HueSector * c) / c;
        end else begin
          hv = ((r - g) * HueSector + 4 * HueSector * c) / c;
        end
        if (hv >= HueFull) hv = HueFull - 1;
        den = mx + mn - CompMax;
        if (den < 0) den = -den;
        den = CompMax - den;
        sv = (den > 0) ? CompMax * c / den : CompMax;
        if (sv > CompMax) sv = CompMax;
      end
      res.hue = hv[14:0];
      res.sat = sv[7:0];
      res.light = 8'((mx + mn) / 2);
    end
    return res;
  endfunction

  // valid stays high between back-to-back transfers; drop it only to idle
  task automatic send_pixel(op_t op, rgb_t rgb, hsl_t hsl);
    while (source_throttle && $urandom_range(99) < 33) begin
      valid <= 1'b0;
      @(negedge clk);
    end
    operation <= op;
    red_in <= rgb.red; green_in <= rgb.green; blue_in <= rgb.blue;
    hue_in <= hsl.hue; saturation_in <= hsl.sat; lightness_in <= hsl.light;
    valid <= 1'b1;
    do @(posedge clk); while (!ready);
    expected_colors.push_back(predict_color(op, rgb, hsl));
    @(negedge clk);
  endtask

  task automatic send_hsl(logic [14:0] h, logic [7:0] s, logic [7:0] l);
    send_pixel(OP_HSL2RGB, '{red: 8'($urandom), green: 8'($urandom), blue: 8'($urandom)},
               '{hue: h, sat: s, light: l});
  endtask

  task automatic send_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    send_pixel(OP_RGB2HSL, '{red: r, green: g, blue: b},
               '{hue: 15'($urandom), sat: 8'($urandom), light: 8'($urandom)});
  endtask

  task automatic wait_drained();
    valid <= 1'b0;
    while (expected_colors.size() != 0) @(negedge clk);
  endtask

  task automatic test_hsl_extremes();
    send_hsl(15'd0, 8'd0, 8'd0);
    send_hsl(15'd0, 8'd255, 8'd255);
    send_hsl(15'd0, 8'd255, 8'd128);
    send_hsl(15'd3840, 8'd255, 8'd127);
    send_hsl(15'd7680, 8'd200, 8'd100);
    send_hsl(15'd11520, 8'd255, 8'd128);
    send_hsl(15'd15360, 8'd128, 8'd200);
    send_hsl(15'd19200, 8'd255, 8'd50);
    send_hsl(15'd23039, 8'd255, 8'd128);
    // hue past full circle falls into the last sector
    send_hsl(15'd23040, 8'd255, 8'd128);
    send_hsl(15'd32767, 8'd255, 8'd128);
  endtask

  task automatic test_rgb_extremes();
    send_rgb(8'd0, 8'd0, 8'd0);
    send_rgb(8'd255, 8'd255, 8'd255);
    send_rgb(8'd128, 8'd128, 8'd128);
    send_rgb(8'd255, 8'd0, 8'd0);
    send_rgb(8'd255, 8'd0, 8'd1);
    send_rgb(8'd0, 8'd255, 8'd0);
    send_rgb(8'd0, 8'd0, 8'd255);
    send_rgb(8'd255, 8'd255, 8'd0);
    send_rgb(8'd0, 8'd255, 8'd255);
    send_rgb(8'd255, 8'd0, 8'd255);
    send_rgb(8'd254, 8'd255, 8'd255);
    send_rgb(8'd1, 8'd0, 8'd0);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1)) send_rgb(8'($urandom), 8'($urandom), 8'($urandom));
      else send_hsl($urandom_range(99) < 5 ? 15'($urandom) : 15'($urandom_range(23039)),
                    8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_back_to_back(int count);
    source_throttle = 1'b0;
    sink_throttle = 1'b0;
    test_random(count);
    wait_drained();
    source_throttle = 1'b1;
    sink_throttle = 1'b1;
  endtask

  // sink side: randomly stall, check every transfer
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !(sink_throttle && $urandom_range(99) < 33);
  end

  always @(posedge clk) begin
    color_t exp_c;
    if (!rst && out_valid && out_ready) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: result with none expected: rgb %0d %0d %0d hsl %0d %0d %0d",
                 $time, red_out, green_out, blue_out, hue_out, saturation_out,
                 lightness_out);
        error_count++;
      end else begin
        exp_c = expected_colors.pop_front();
        if (red_out !== exp_c.red || green_out !== exp_c.green ||
            blue_out !== exp_c.blue || hue_out !== exp_c.hue ||
            saturation_out !== exp_c.sat || lightness_out !== exp_c.light) begin
          $display("%0t: mismatch expected rgb %0d %0d %0d hsl %0d %0d %0d",
                   $time, exp_c.red, exp_c.green, exp_c.blue, exp_c.hue, exp_c.sat,
                   exp_c.light);
          $display("%0t:          actual   rgb %0d %0d %0d hsl %0d %0d %0d",
                   $time, red_out, green_out, blue_out, hue_out, saturation_out,
                   lightness_out);
          error_count++;
        end
      end
    end
  end

  // watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (valid && ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("tb_hsl_rgb_converter_unit: errors");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    source_throttle = 1'b1;
    sink_throttle = 1'b1;
    rst = 1'b1;
    valid = 1'b0;
    out_ready = 1'b0;
    operation = OP_HSL2RGB;
    red_in = '0; green_in = '0; blue_in = '0;
    hue_in = '0; saturation_in = '0; lightness_in = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_hsl_extremes();
    test_rgb_extremes();
    test_random(600);
    // hold the source until the pipe is empty
    wait_drained();
    test_back_to_back(250);
    test_random(600);
    wait_drained();
    repeat (Latency + 4) @(posedge clk);
    if (error_count == 0 && expected_colors.size() == 0) begin
      $display("tb_hsl_rgb_converter_unit: clean");
    end else begin
      $display("tb_hsl_rgb_converter_unit: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hslc_pkg.sv
rtl/core/hslc_pipe_ctl.sv
rtl/core/hslc_h2r.sv
rtl/core/hslc_r2h.sv
rtl/core/hsl_rgb_converter_unit.sv
verif/tb_hsl_rgb_converter_unit.sv
